// ===== hw/rtl/sirc_pkg.sv =====
// types, constants and reciprocal table for the radix text converter
`timescale 1ns / 1ps
`default_nettype none

package sirc_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 64;
  localparam int unsigned SLOTS     = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned MAX_DIGITS = 32;
  localparam int unsigned NDIG_W    = 6;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CHAR_W-1:0]         char_t;
  typedef logic [RADIX_W-1:0]        radix_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0]      cfg_dat_t;

  // register indexes
  localparam cfg_idx_t CFG_RADIX        = 8'd0;
  localparam cfg_idx_t CFG_SYMBOLS_LOW  = 8'd1;
  localparam cfg_idx_t CFG_SYMBOLS_HIGH = 8'd2;

  localparam char_t  CHAR_MINUS = 8'h2D;
  localparam char_t  CHAR_PLUS  = 8'h2B;
  localparam char_t  CHAR_LOW   = 8'd32;
  localparam char_t  CHAR_HIGH  = 8'd126;
  localparam radix_t MIN_RADIX  = 5'd2;

  // floor(2^32 / r): estimate of the quotient is exact or one short
  function automatic logic [31:0] recip(input radix_t r);
    logic [31:0] res;
    case (r)
      5'd2:    res = 32'h8000_0000;
      5'd3:    res = 32'h5555_5555;
      5'd4:    res = 32'h4000_0000;
      5'd5:    res = 32'h3333_3333;
      5'd6:    res = 32'h2AAA_AAAA;
      5'd7:    res = 32'h2492_4924;
      5'd8:    res = 32'h2000_0000;
      5'd9:    res = 32'h1C71_C71C;
      5'd10:   res = 32'h1999_9999;
      5'd11:   res = 32'h1745_D174;
      5'd12:   res = 32'h1555_5555;
      5'd13:   res = 32'h13B1_3B13;
      5'd14:   res = 32'h1249_2492;
      5'd15:   res = 32'h1111_1111;
      5'd16:   res = 32'h1000_0000;
      default: res = 32'h0000_0000;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sirc_if.sv =====
// valid/ready channel interfaces: value in, character out, register writes
`timescale 1ns / 1ps
`default_nettype none

interface sirc_in_if;
  logic            valid;
  logic            ready;
  sirc_pkg::value_t value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sirc_out_if;
  logic            valid;
  logic            ready;
  sirc_pkg::char_t character;
  logic            last;
  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface sirc_cfg_if;
  logic               valid;
  logic               ready;
  sirc_pkg::cfg_idx_t index;
  sirc_pkg::cfg_dat_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/signed_int_to_radix_chars_core.sv =====
// signed 32-bit value to text in a configurable radix, one character per word
//
//  channel | dir | payload            | word
//  in_i    | in  | value[31:0] signed | one value to convert
//  out_o   | out | character[7:0],last| one character, last marks end of text
//  cfg_i   | in  | index[7:0],data[63:0] | register write, always ready
//
// a value passes the symbol check, then takes a multiply and a correction step per digit
// on the shared 32x32 reciprocal multiplier, then the sign and one character per cycle go
// out while the receiver is ready
// no new value is taken until the last character sits in the output register
// output stalls hold the sequencer in the sign and emit states; reset clears registers to 0
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_radix_chars_core #(
  parameter int unsigned MAX_BASE = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  sirc_in_if.sink        in_i,
  sirc_out_if.source     out_o,
  sirc_cfg_if.sink       cfg_i
);

  localparam int unsigned DIGIT_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_CORR,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [31:0]                   mag_q, mag_d;
  logic                          neg_q, neg_d;
  logic [sirc_pkg::NDIG_W-1:0]   ndig_q, ndig_d;
  logic [63:0]                   prod_q, prod_d;
  logic                          out_valid_q, out_valid_d;
  sirc_pkg::char_t               out_char_q, out_char_d;
  logic                          out_last_q, out_last_d;
  sirc_pkg::radix_t              radix_q, radix_d;
  sirc_pkg::cfg_dat_t            sym_lo_q, sym_lo_d;
  sirc_pkg::cfg_dat_t            sym_hi_q, sym_hi_d;

  logic [DIGIT_W-1:0]            digit_mem [sirc_pkg::MAX_DIGITS];
  logic                          digit_we;
  logic [DIGIT_W-1:0]            digit_wr;

  sirc_pkg::char_t               sym [sirc_pkg::SLOTS];
  logic                          set_ok;
  logic                          slot_free;
  logic [31:0]                   val_u;
  logic [31:0]                   q_est, qr, rem_raw, rem_fix, q_fix;
  logic                          corr;
  logic [4:0]                    rd_idx;
  logic [DIGIT_W-1:0]            rd_digit;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      sym[k]     = sym_lo_q[8*k +: 8];
      sym[k + 8] = sym_hi_q[8*k +: 8];
    end
  end

  // symbol set check over the slots in use
  always_comb begin
    set_ok = (radix_q >= sirc_pkg::MIN_RADIX) &&
             (32'(radix_q) <= MAX_BASE) &&
             (32'(radix_q) <= sirc_pkg::SLOTS);
    for (int i = 0; i < sirc_pkg::SLOTS; i++) begin
      if (5'(i) < radix_q) begin
        if (sym[i] == sirc_pkg::CHAR_MINUS || sym[i] == sirc_pkg::CHAR_PLUS ||
            sym[i] <= sirc_pkg::CHAR_LOW || sym[i] > sirc_pkg::CHAR_HIGH) begin
          set_ok = 1'b0;
        end
        for (int j = i + 1; j < sirc_pkg::SLOTS; j++) begin
          if (5'(j) < radix_q && sym[j] == sym[i]) begin
            set_ok = 1'b0;
          end
        end
      end
    end
  end

  // quotient estimate from the registered product, then one correction step
  assign q_est   = prod_q[63:32];
  assign qr      = q_est * 32'(radix_q);
  assign rem_raw = mag_q - qr;
  assign corr    = rem_raw >= 32'(radix_q);
  assign rem_fix = corr ? (rem_raw - 32'(radix_q)) : rem_raw;
  assign q_fix   = q_est + 32'(corr);

  assign val_u     = in_i.value;
  assign slot_free = !out_valid_q || out_o.ready;
  assign rd_idx    = 5'(ndig_q - 6'd1);
  assign rd_digit  = digit_mem[rd_idx];

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    ndig_d      = ndig_q;
    prod_d      = prod_q;
    out_valid_d = out_o.ready ? 1'b0 : out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    radix_d     = radix_q;
    sym_lo_d    = sym_lo_q;
    sym_hi_d    = sym_hi_q;
    digit_we    = 1'b0;
    digit_wr    = DIGIT_W'(rem_fix);

    if (cfg_i.valid) begin
      case (cfg_i.index)
        sirc_pkg::CFG_RADIX:        radix_d  = cfg_i.data[sirc_pkg::RADIX_W-1:0];
        sirc_pkg::CFG_SYMBOLS_LOW:  sym_lo_d = cfg_i.data;
        sirc_pkg::CFG_SYMBOLS_HIGH: sym_hi_d = cfg_i.data;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          neg_d   = val_u[31];
          mag_d   = val_u[31] ? (32'd0 - val_u) : val_u;
          ndig_d  = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = set_ok ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        prod_d  = 64'(mag_q) * 64'(sirc_pkg::recip(radix_q));
        state_d = ST_CORR;
      end
      ST_CORR: begin
        digit_we = 1'b1;
        mag_d    = q_fix;
        ndig_d   = ndig_q + 6'd1;
        if (q_fix == 32'd0 || ndig_q == 6'(sirc_pkg::MAX_DIGITS - 1)) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (!neg_q) begin
          state_d = ST_EMIT;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sirc_pkg::CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sym[sirc_pkg::SLOT_W'(rd_digit)];
          out_last_d  = (ndig_q == 6'd1);
          ndig_d      = ndig_q - 6'd1;
          if (ndig_q == 6'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      ndig_q      <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      radix_q     <= '0;
      sym_lo_q    <= '0;
      sym_hi_q    <= '0;
    end else begin
      state_q     <= state_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      ndig_q      <= ndig_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
      radix_q     <= radix_d;
      sym_lo_q    <= sym_lo_d;
      sym_hi_q    <= sym_hi_d;
    end
  end

  // digit buffer, least significant digit at the bottom
  always_ff @(posedge clk_i) begin
    if (digit_we) begin
      digit_mem[ndig_q[4:0]] <= digit_wr;
    end
  end

  // the one correction step always lands the remainder below the radix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORR) |-> (rem_raw < {26'd0, radix_q, 1'b0}))
    else $error("quotient estimate off by more than one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CORR) |-> (rem_fix < 32'(radix_q)))
    else $error("digit not below radix");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndig_q <= 6'(sirc_pkg::MAX_DIGITS))
    else $error("digit count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (ndig_q != 6'd0))
    else $error("emit with empty digit buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && slot_free && ndig_q == 6'd1) |=> out_valid_q && out_last_q)
    else $error("final character not marked last");

endmodule

`default_nettype wire

// ===== test/sirc_text_checker.sv =====
// checker for the radix text converter: tracks the registers, predicts the text and compares
`timescale 1ns / 1ps

module sirc_text_checker #(
  parameter int unsigned MAX_BASE = 16
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  sirc_in_if   in_mon_i,
  sirc_out_if  out_mon_i,
  sirc_cfg_if  cfg_mon_i,
  output int   mismatch_count_o,
  output int   pending_o
);

  import sirc_pkg::*;

  typedef struct packed {
    char_t character;
    logic  last;
  } text_char_t;

  radix_t       radix_r;
  logic [127:0] symbols_r;   // symbol k at bits 8k
  text_char_t   text_q[$];

  function automatic char_t symbol_of(input logic [3:0] slot);
    return symbols_r[8*slot +: 8];
  endfunction

  function automatic bit set_is_usable();
    char_t s;
    bit    ok;
    ok = (radix_r >= MIN_RADIX) && (int'(radix_r) <= int'(MAX_BASE));
    for (int i = 0; ok && i < int'(radix_r); i++) begin
      s = symbol_of(4'(i));
      if (s == CHAR_MINUS || s == CHAR_PLUS || s <= CHAR_LOW || s > CHAR_HIGH) begin
        ok = 1'b0;
      end
      for (int j = i + 1; j < int'(radix_r); j++) begin
        if (symbol_of(4'(j)) == s) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // digits come out least significant first, then go on the queue reversed
  function automatic void queue_text(input value_t v);
    logic [31:0] raw;
    logic [31:0] mag;
    char_t       digits[32];
    int          n;
    if (!set_is_usable()) begin
      return;
    end
    raw = v;
    mag = raw[31] ? (32'd0 - raw) : raw;
    n   = 0;
    do begin
      digits[n] = symbol_of(4'(mag % radix_r));
      n++;
      mag = mag / radix_r;
    end while (mag != 0);
    if (raw[31]) begin
      text_q.push_back(text_char_t'{character: CHAR_MINUS, last: 1'b0});
    end
    for (int k = n - 1; k >= 0; k--) begin
      text_q.push_back(text_char_t'{character: digits[k], last: (k == 0)});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      radix_r          = '0;
      symbols_r        = '0;
      text_q.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          CFG_RADIX:        radix_r = cfg_mon_i.data[RADIX_W-1:0];
          CFG_SYMBOLS_LOW:  symbols_r[63:0] = cfg_mon_i.data;
          CFG_SYMBOLS_HIGH: symbols_r[127:64] = cfg_mon_i.data;
          default: ;
        endcase
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (text_q.size() == 0) begin
          $display("%0t: expected no word, got character %h last %b", $time,
                   out_mon_i.character, out_mon_i.last);
          mismatch_count_o++;
        end else begin
          want = text_q.pop_front();
          if (out_mon_i.character !== want.character) begin
            $display("%0t: character expected %h got %h", $time, want.character,
                     out_mon_i.character);
            mismatch_count_o++;
          end
          if (out_mon_i.last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, out_mon_i.last);
            mismatch_count_o++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        queue_text(in_mon_i.value);
      end
      pending_o = text_q.size();
    end
  end

endmodule

// ===== test/tb_signed_int_to_radix_chars_core.sv =====
// testbench top for the radix text converter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_signed_int_to_radix_chars_core;

  import sirc_pkg::*;

  localparam int unsigned MAX_BASE     = 16;
  localparam int          DRAIN_CYCLES = 150;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          PHASES       = 25;
  localparam int          PHASE_ITEMS  = 20;

  // symbol words: decimal, binary and hex digit sets
  localparam cfg_dat_t DEC_LOW  = 64'h3736_3534_3332_3130;
  localparam cfg_dat_t DEC_HIGH = 64'h0000_0000_0000_3938;
  localparam cfg_dat_t HEX_HIGH = 64'h4645_4443_4241_3938;
  localparam cfg_dat_t BIN_LOW  = 64'h0000_0000_0000_3130;

  typedef enum int {
    FLAW_FEW, FLAW_WIDE, FLAW_SIGN, FLAW_LOW_BYTE, FLAW_HIGH_BYTE, FLAW_REPEAT
  } flaw_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   src_idle_pct;
  int   sink_idle_pct;
  bit   hold_req;
  int   mismatch_count;
  int   pending;
  int   stall_cycles;

  sirc_in_if  in_w ();
  sirc_out_if out_w ();
  sirc_cfg_if cfg_w ();

  signed_int_to_radix_chars_core #(.MAX_BASE(MAX_BASE)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w),
    .cfg_i  (cfg_w)
  );

  sirc_text_checker #(.MAX_BASE(MAX_BASE)) text_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon_i         (in_w),
    .out_mon_i        (out_w),
    .cfg_mon_i        (cfg_w),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // nothing accepted on any channel for too long means the block has hung
  always @(posedge clk_i) begin
    if (!rst_ni || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)
        || (cfg_w.valid && cfg_w.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_w.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          out_w.ready <= 1'b0;
          @(negedge clk_i);
        end
      end
      out_w.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input cfg_dat_t data);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= idx;
    cfg_w.data  <= data;
    do @(posedge clk_i); while (!cfg_w.ready);
    @(negedge clk_i);
  endtask

  task automatic send_value(input value_t v);
    if ($urandom_range(99) < src_idle_pct) begin
      in_w.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_w.valid <= 1'b1;
    in_w.value <= v;
    do @(posedge clk_i); while (!in_w.ready);
    @(negedge clk_i);
  endtask

  // invalid sets give no text, so the block may still be busy after the queue drains
  task automatic settle();
    in_w.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_set(input cfg_dat_t radix_word, input cfg_dat_t lo, input cfg_dat_t hi,
                          input bit stray, input cfg_idx_t stray_idx);
    settle();
    write_reg(CFG_RADIX, radix_word);
    write_reg(CFG_SYMBOLS_LOW, lo);
    write_reg(CFG_SYMBOLS_HIGH, hi);
    if (stray) begin
      write_reg(stray_idx, {$urandom, $urandom} | radix_word);
    end
    cfg_w.valid <= 1'b0;
  endtask

  task automatic random_set(input bit allow_flaw, output cfg_dat_t radix_word,
                            output logic [127:0] syms);
    int    r;
    int    slot;
    int    other;
    char_t b;
    bit    clash;
    flaw_e flaw;
    case ($urandom_range(3))
      0:       r = MIN_RADIX;
      1:       r = MAX_BASE;
      default: r = $urandom_range(MIN_RADIX, MAX_BASE);
    endcase
    // slots past the radix keep random bytes
    syms = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < r; i++) begin
      do begin
        b     = char_t'($urandom_range(CHAR_LOW + 1, CHAR_HIGH));
        clash = (b == CHAR_PLUS) || (b == CHAR_MINUS);
        for (int j = 0; j < i; j++) begin
          if (syms[8*j +: 8] == b) begin
            clash = 1'b1;
          end
        end
      end while (clash);
      syms[8*i +: 8] = b;
    end
    if (allow_flaw && $urandom_range(99) < 15) begin
      flaw = flaw_e'($urandom_range(FLAW_REPEAT));
      slot = $urandom_range(r - 1);
      case (flaw)
        FLAW_FEW:       r = $urandom_range(MIN_RADIX - 1);
        FLAW_WIDE:      r = $urandom_range(MAX_BASE + 1, (1 << RADIX_W) - 1);
        FLAW_SIGN:      syms[8*slot +: 8] = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
        FLAW_LOW_BYTE:  syms[8*slot +: 8] = char_t'($urandom_range(CHAR_LOW));
        FLAW_HIGH_BYTE: syms[8*slot +: 8] = char_t'($urandom_range(CHAR_HIGH + 1, 255));
        FLAW_REPEAT: begin
          other = (slot + 1 + $urandom_range(r - 2)) % r;
          syms[8*other +: 8] = syms[8*slot +: 8];
        end
        default: ;
      endcase
    end
    // only the low bits of the radix word count
    radix_word = {$urandom, 27'($urandom), 5'(r)};
  endtask

  function automatic value_t random_value();
    value_t v;
    case ($urandom_range(7))
      0: v = value_t'($urandom_range(40));
      1: v = -value_t'($urandom_range(1, 40));
      2: begin
        case ($urandom_range(3))
          0:       v = {1'b0, {31{1'b1}}};
          1:       v = {1'b1, 31'd0};
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    cfg_dat_t     radix_word;
    logic [127:0] syms;
    rst_ni        = 1'b0;
    hold_req      = 1'b0;
    src_idle_pct  = 10;
    sink_idle_pct = 63;
    in_w.valid    = 1'b0;
    in_w.value    = '0;
    cfg_w.valid   = 1'b0;
    cfg_w.index   = CFG_RADIX;
    cfg_w.data    = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers still zero after reset: no text
    send_value(value_t'(1234));

    load_set(10, DEC_LOW, DEC_HIGH, 1'b0, CFG_RADIX);
    send_value('0);
    send_value(value_t'(1));
    send_value('1);
    send_value({1'b0, {31{1'b1}}});
    send_value({1'b1, 31'd0});
    send_value(value_t'(10));
    send_value(-value_t'(10));

    // longest text: most negative value in base 2
    load_set(2, BIN_LOW, DEC_HIGH, 1'b0, CFG_RADIX);
    send_value({1'b1, 31'd0});
    send_value({1'b0, {31{1'b1}}});

    load_set(16, DEC_LOW, HEX_HIGH, 1'b0, CFG_RADIX);
    send_value({1'b1, 31'd0});
    send_value(value_t'(32'hDEAD_BEEF));

    // broken symbol sets
    load_set(1, DEC_LOW, DEC_HIGH, 1'b0, CFG_RADIX);
    send_value(value_t'(5));
    load_set(17, DEC_LOW, HEX_HIGH, 1'b0, CFG_RADIX);
    send_value(value_t'(5));
    load_set('1, DEC_LOW, HEX_HIGH, 1'b0, CFG_RADIX);
    send_value(value_t'(5));
    load_set(10, 64'h3736_3534_2B32_3130, DEC_HIGH, 1'b0, CFG_RADIX);
    send_value(value_t'(5));
    load_set(10, 64'h3736_3534_3332_312D, DEC_HIGH, 1'b0, CFG_RADIX);
    send_value(value_t'(5));
    load_set(10, 64'h3736_3534_3332_2030, DEC_HIGH, 1'b0, CFG_RADIX);
    send_value(value_t'(5));
    load_set(10, DEC_LOW, 64'h0000_0000_0000_7F38, 1'b0, CFG_RADIX);
    send_value(value_t'(5));
    load_set(10, DEC_LOW, 64'h0000_0000_0000_3038, 1'b0, CFG_RADIX);
    send_value(value_t'(5));

    // printable extremes as symbols
    load_set(2, 64'h0000_0000_0000_7E21, '0, 1'b0, CFG_RADIX);
    send_value(-value_t'(5));
    send_value({1'b0, {31{1'b1}}});

    // garbage beyond the radix is ignored
    load_set(3, 64'hFF2D_2B00_0032_3130, '1, 1'b0, CFG_RADIX);
    send_value({1'b1, 31'd0});

    // write to an unused index changes nothing
    load_set(10, DEC_LOW, DEC_HIGH, 1'b1, cfg_idx_t'(CFG_SYMBOLS_HIGH + 1));
    send_value(value_t'(255));

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        src_idle_pct  = 63;
        sink_idle_pct = 10;
      end else if (p == 2 * PHASES / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      // the hold-off phase needs a usable set so the block backs up
      random_set(p != 3, radix_word, syms);
      load_set(radix_word, syms[63:0], syms[127:64], $urandom_range(9) == 0,
               cfg_idx_t'($urandom_range(CFG_SYMBOLS_HIGH + 1, (1 << CFG_IDX_W) - 1)));
      if (p == 3) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_value(random_value());
    end

    settle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sirc_pkg.sv
hw/rtl/sirc_if.sv
hw/rtl/signed_int_to_radix_chars_core.sv
test/sirc_text_checker.sv
test/tb_signed_int_to_radix_chars_core.sv
